>>> src/bpbb_pkg.sv
// ----------------------------------------------------------------------------
// bpbb_pkg
// Types and constants shared by the path bounding box controller and datapath.
// ----------------------------------------------------------------------------
package bpbb_pkg;

	localparam int CW    = 32;           // coordinate width, signed fixed point
	localparam int FB    = 16;           // fraction bits of the curve parameter
	localparam int TW    = FB + 1;       // parameter t, 0 .. 2^FB
	localparam int KW    = CW + 3;       // cubic coefficient width
	localparam int MW    = KW;           // coefficient magnitude width
	localparam int PW    = 2 * MW;       // product width
	localparam int DW    = 2 * CW + 4;   // discriminant width (even)
	localparam int SW    = DW / 2;       // square root width
	localparam int NW    = CW + 5;       // divider numerator and divisor width
	localparam int IN_W  = 8 * CW;
	localparam int OUT_W = 4 * CW;
	localparam int CNT_W = $clog2(MW);

	typedef enum logic [1:0] {
		CMD_SEED  = 2'd0,
		CMD_LINE  = 2'd1,
		CMD_QUAD  = 2'd2,
		CMD_CUBIC = 2'd3
	} seg_kind_t;

	typedef enum logic [1:0] {
		SRC_LIN    = 2'd0,
		SRC_ROOT_P = 2'd1,
		SRC_ROOT_M = 2'd2
	} div_src_t;

	typedef struct packed {
		logic signed [CW-1:0] max_y;
		logic signed [CW-1:0] max_x;
		logic signed [CW-1:0] min_y;
		logic signed [CW-1:0] min_x;
	} box_t;

	typedef struct packed {
		logic     load_in;
		logic     seed;
		logic     grow_ends;
		logic     coef;
		logic     axis;
		logic     mul_load;
		logic     mul_step;
		logic     sqrt_load;
		logic     sqrt_step;
		div_src_t div_src;
		logic     div_load;
		logic     div_step;
		logic     eval_load;
		logic     eval_step;
		logic     eval_grow;
		logic     emit;
	} dp_cmd_t;

	typedef struct packed {
		seg_kind_t kind;
		logic      last;
		logic      seeded;
		logic      a_zero;
		logic      div_ok;
		logic      div_eq;
		logic      disc_neg;
		logic      out_busy;
	} dp_stat_t;

endpackage

>>> src/bpbb_dp.sv
// ----------------------------------------------------------------------------
// bpbb_dp
// Datapath: segment registers, running box, shift-add multiplier, digit
// square root, restoring divider and de Casteljau evaluation lanes.
// ----------------------------------------------------------------------------
module bpbb_dp import bpbb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  s_data,
	input  logic [1:0]       s_kind,
	input  logic             s_last,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  logic             m_ready,
	output logic             m_valid,
	output logic [OUT_W-1:0] m_data
);

	logic signed [CW-1:0] px_q [4];
	logic signed [CW-1:0] py_q [4];
	seg_kind_t            kind_q;
	logic                 last_q;

	box_t                 box_q;
	logic                 seeded_q;
	logic                 out_valid_q;
	box_t                 out_q;

	logic signed [KW-1:0] a_q, h_q, c_q;
	logic [PW-1:0]        hh_q, ac_q, msh_h_q, msh_a_q;
	logic [MW-1:0]        mb_h_q, mb_c_q;
	logic                 ac_neg_q;
	logic [DW-1:0]        sq_d_q;
	logic [SW+1:0]        rem_q;
	logic [SW-1:0]        root_q;
	logic [NW-1:0]        div_r_q, div_d_q;
	logic [FB-1:0]        div_q_q;
	logic                 div_ok_q, div_eq_q;
	logic signed [CW-1:0] pt_x_q [4];
	logic signed [CW-1:0] pt_y_q [4];
	logic [TW-1:0]        t_q;

	logic signed [KW-1:0] e [4];
	logic signed [KW-1:0] d12, a_c, h_c, c_c;
	logic signed [NW-1:0] n0, d0, n1, d1;
	logic [PW:0]          disc_w;
	logic                 disc_neg;
	logic [SW+3:0]        rem_sh, trial, rem_df;
	logic [NW:0]          r2, r2_df;
	logic [1:0]           end_idx;

	function automatic logic [MW-1:0] mag(input logic signed [KW-1:0] v);
		return v[KW-1] ? MW'(-v) : MW'(v);
	endfunction

	function automatic logic signed [CW-1:0] lerp(input logic signed [CW-1:0] p,
		input logic signed [CW-1:0] q, input logic [TW-1:0] t);
		logic signed [CW:0]      d;
		logic signed [CW+TW+1:0] pr;
		d  = (CW+1)'(q) - (CW+1)'(p);
		pr = d * $signed({1'b0, t});
		return p + pr[FB+CW-1:FB];
	endfunction

	function automatic box_t grow(input box_t b, input logic signed [CW-1:0] x,
		input logic signed [CW-1:0] y);
		box_t r;
		r = b;
		if (x < b.min_x) r.min_x = x;
		if (x > b.max_x) r.max_x = x;
		if (y < b.min_y) r.min_y = y;
		if (y > b.max_y) r.max_y = y;
		return r;
	endfunction

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			e[i] = cmd.axis ? KW'(py_q[i]) : KW'(px_q[i]);
		end
		d12 = e[1] - e[2];
		a_c = e[3] - e[0] + (d12 <<< 1) + d12;
		h_c = e[0] - (e[1] <<< 1) + e[2];
		c_c = e[1] - e[0];
	end

	always_comb begin
		case (cmd.div_src)
			SRC_LIN: begin
				n0 = -NW'(c_q);
				d0 = (kind_q == CMD_CUBIC) ? (NW'(h_q) <<< 1) : NW'(h_q);
			end
			SRC_ROOT_P: begin
				n0 = -NW'(h_q) + $signed(NW'(root_q));
				d0 = NW'(a_q);
			end
			SRC_ROOT_M: begin
				n0 = -NW'(h_q) - $signed(NW'(root_q));
				d0 = NW'(a_q);
			end
			default: begin
				n0 = '0;
				d0 = '0;
			end
		endcase
		if (d0 < 0) begin
			n1 = -n0;
			d1 = -d0;
		end else begin
			n1 = n0;
			d1 = d0;
		end
	end

	always_comb begin
		if (ac_neg_q) disc_w = {1'b0, hh_q} + {1'b0, ac_q};
		else          disc_w = {1'b0, hh_q} - {1'b0, ac_q};
		disc_neg = !ac_neg_q && (hh_q < ac_q);
		rem_sh   = {rem_q, sq_d_q[DW-1:DW-2]};
		trial    = {2'b00, root_q, 2'b01};
		rem_df   = rem_sh - trial;
		r2       = {div_r_q, 1'b0};
		r2_df    = r2 - {1'b0, div_d_q};
		case (kind_q)
			CMD_LINE: end_idx = 2'd1;
			CMD_QUAD: end_idx = 2'd2;
			default:  end_idx = 2'd3;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			for (int i = 0; i < 4; i++) begin
				px_q[i] <= s_data[2*i*CW +: CW];
				py_q[i] <= s_data[(2*i+1)*CW +: CW];
			end
			kind_q <= seg_kind_t'(s_kind);
			last_q <= s_last;
		end
		if (cmd.coef) begin
			a_q <= a_c;
			h_q <= h_c;
			c_q <= c_c;
		end
		if (cmd.mul_load) begin
			hh_q     <= '0;
			ac_q     <= '0;
			msh_h_q  <= PW'(mag(h_q));
			mb_h_q   <= mag(h_q);
			msh_a_q  <= PW'(mag(a_q));
			mb_c_q   <= mag(c_q);
			ac_neg_q <= (c_q != 0) && (a_q[KW-1] ^ c_q[KW-1]);
		end else if (cmd.mul_step) begin
			if (mb_h_q[0]) hh_q <= hh_q + msh_h_q;
			if (mb_c_q[0]) ac_q <= ac_q + msh_a_q;
			msh_h_q <= msh_h_q << 1;
			msh_a_q <= msh_a_q << 1;
			mb_h_q  <= mb_h_q >> 1;
			mb_c_q  <= mb_c_q >> 1;
		end
		if (cmd.sqrt_load) begin
			sq_d_q <= disc_w[DW-1:0];
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			sq_d_q <= sq_d_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_df[SW+1:0];
				root_q <= {root_q[SW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[SW+1:0];
				root_q <= {root_q[SW-2:0], 1'b0};
			end
		end
		if (cmd.div_load) begin
			div_r_q  <= n1;
			div_d_q  <= d1;
			div_q_q  <= '0;
			div_ok_q <= (d1 != 0) && !n1[NW-1] && (n1 <= d1);
			div_eq_q <= (n1 == d1);
		end else if (cmd.div_step) begin
			if (r2 >= {1'b0, div_d_q}) begin
				div_r_q <= r2_df[NW-1:0];
				div_q_q <= {div_q_q[FB-2:0], 1'b1};
			end else begin
				div_r_q <= r2[NW-1:0];
				div_q_q <= {div_q_q[FB-2:0], 1'b0};
			end
		end
		if (cmd.eval_load) begin
			for (int i = 0; i < 4; i++) begin
				pt_x_q[i] <= px_q[i];
				pt_y_q[i] <= py_q[i];
			end
			t_q <= div_eq_q ? {1'b1, {FB{1'b0}}} : {1'b0, div_q_q};
		end else if (cmd.eval_step) begin
			for (int i = 0; i < 3; i++) begin
				pt_x_q[i] <= lerp(pt_x_q[i], pt_x_q[i+1], t_q);
				pt_y_q[i] <= lerp(pt_y_q[i], pt_y_q[i+1], t_q);
			end
		end
		if (cmd.emit) out_q <= seeded_q ? box_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q       <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.seed) begin
				box_q.min_x <= px_q[0];
				box_q.max_x <= px_q[0];
				box_q.min_y <= py_q[0];
				box_q.max_y <= py_q[0];
				seeded_q    <= 1'b1;
			end else if (cmd.grow_ends) begin
				box_q <= grow(grow(box_q, px_q[0], py_q[0]), px_q[end_idx], py_q[end_idx]);
			end else if (cmd.eval_grow) begin
				box_q <= grow(box_q, pt_x_q[0], pt_y_q[0]);
			end else if (cmd.emit) begin
				box_q    <= '0;
				seeded_q <= 1'b0;
			end
			if (cmd.emit)        out_valid_q <= 1'b1;
			else if (m_ready)    out_valid_q <= 1'b0;
		end
	end

	assign stat.kind     = kind_q;
	assign stat.last     = last_q;
	assign stat.seeded   = seeded_q;
	assign stat.a_zero   = (a_q == 0);
	assign stat.div_ok   = div_ok_q;
	assign stat.div_eq   = div_eq_q;
	assign stat.disc_neg = disc_neg;
	assign stat.out_busy = out_valid_q && !m_ready;

	assign m_valid = out_valid_q;
	assign m_data  = out_q;

endmodule

>>> src/bpbb_ctrl.sv
// ----------------------------------------------------------------------------
// bpbb_ctrl
// Sequencer: walks each segment through end points, curve roots per axis and
// evaluation, and after a last word hands the box to the output register.
// ----------------------------------------------------------------------------
module bpbb_ctrl import bpbb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_valid,
	output logic     s_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISPATCH, ST_COEF, ST_COEF_CHK, ST_MUL, ST_DISC, ST_SQRT,
		ST_DIV_LOAD, ST_DIV_CHK, ST_DIV, ST_EVAL_LOAD, ST_EVAL, ST_EVAL_GROW,
		ST_CAND_DONE, ST_NEXT_AXIS, ST_FINISH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             axis_q;
	div_src_t         src_q;
	logic             emit_wait_q;
	logic [CNT_W-1:0] eval_last;

	assign eval_last = (stat.kind == CMD_CUBIC) ? CNT_W'(2) : CNT_W'(1);
	assign s_ready   = (state_q == ST_IDLE) && !emit_wait_q;

	always_comb begin
		cmd           = '0;
		cmd.axis      = axis_q;
		cmd.div_src   = src_q;
		cmd.load_in   = s_ready && s_valid;
		cmd.seed      = (state_q == ST_DISPATCH) && (stat.kind == CMD_SEED);
		cmd.grow_ends = (state_q == ST_DISPATCH) && (stat.kind != CMD_SEED) && stat.seeded;
		cmd.coef      = (state_q == ST_COEF);
		cmd.mul_load  = (state_q == ST_COEF_CHK) && (stat.kind == CMD_CUBIC) && !stat.a_zero;
		cmd.mul_step  = (state_q == ST_MUL);
		cmd.sqrt_load = (state_q == ST_DISC);
		cmd.sqrt_step = (state_q == ST_SQRT);
		cmd.div_load  = (state_q == ST_DIV_LOAD);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.eval_load = (state_q == ST_EVAL_LOAD);
		cmd.eval_step = (state_q == ST_EVAL);
		cmd.eval_grow = (state_q == ST_EVAL_GROW);
		cmd.emit      = (state_q == ST_IDLE) && emit_wait_q && !stat.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			axis_q      <= 1'b0;
			src_q       <= SRC_LIN;
			emit_wait_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(1);
			case (state_q)
				ST_IDLE: begin
					if (emit_wait_q) begin
						if (!stat.out_busy) emit_wait_q <= 1'b0;
					end else if (s_valid) begin
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					axis_q <= 1'b0;
					if (stat.seeded && (stat.kind == CMD_QUAD || stat.kind == CMD_CUBIC))
						state_q <= ST_COEF;
					else
						state_q <= ST_FINISH;
				end
				ST_COEF: state_q <= ST_COEF_CHK;
				ST_COEF_CHK: begin
					cnt_q <= '0;
					if (stat.kind == CMD_QUAD || stat.a_zero) begin
						src_q   <= SRC_LIN;
						state_q <= ST_DIV_LOAD;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: if (cnt_q == CNT_W'(MW-1)) state_q <= ST_DISC;
				ST_DISC: begin
					cnt_q   <= '0;
					state_q <= stat.disc_neg ? ST_NEXT_AXIS : ST_SQRT;
				end
				ST_SQRT: begin
					if (cnt_q == CNT_W'(SW-1)) begin
						src_q   <= SRC_ROOT_P;
						state_q <= ST_DIV_LOAD;
					end
				end
				ST_DIV_LOAD: state_q <= ST_DIV_CHK;
				ST_DIV_CHK: begin
					cnt_q <= '0;
					if (!stat.div_ok)     state_q <= ST_CAND_DONE;
					else if (stat.div_eq) state_q <= ST_EVAL_LOAD;
					else                  state_q <= ST_DIV;
				end
				ST_DIV: if (cnt_q == CNT_W'(FB-1)) state_q <= ST_EVAL_LOAD;
				ST_EVAL_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_EVAL;
				end
				ST_EVAL: if (cnt_q == eval_last) state_q <= ST_EVAL_GROW;
				ST_EVAL_GROW: state_q <= ST_CAND_DONE;
				ST_CAND_DONE: begin
					if (src_q == SRC_ROOT_P) begin
						src_q   <= SRC_ROOT_M;
						state_q <= ST_DIV_LOAD;
					end else begin
						state_q <= ST_NEXT_AXIS;
					end
				end
				ST_NEXT_AXIS: begin
					if (!axis_q) begin
						axis_q  <= 1'b1;
						state_q <= ST_COEF;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (stat.last) emit_wait_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> src/bezier_path_bounding_box_top.sv
// ----------------------------------------------------------------------------
// bezier_path_bounding_box_top
// Tight bounding box of a path of seed, line, quadratic and cubic segments.
// Quadratic segments use the restoring divider; cubic segments may also use
// the shift-add multiplier and the digit square root. One word is worked at
// a time; after a last word the box word becomes valid in the same cycle
// that input resumes; both wait while an earlier box word is held by m_tready.
// Asynchronous reset clears the box, the seed flag and control.
// ----------------------------------------------------------------------------
module bezier_path_bounding_box_top import bpbb_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
	input  logic [1:0]       s_tuser,   // cmd
	input  logic             s_tlast,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // box_min_x, box_min_y, box_max_x, box_max_y
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bpbb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bpbb_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_data  (s_tdata),
		.s_kind  (s_tuser),
		.s_last  (s_tlast),
		.cmd     (cmd),
		.stat    (stat),
		.m_ready (m_tready),
		.m_valid (m_tvalid),
		.m_data  (m_tdata)
	);

endmodule

>>> tb/sv/tb_bezier_path_bounding_box_top.sv
// ----------------------------------------------------------------------------
// tb_bezier_path_bounding_box_top
// Self-checking bench for the path bounding box block. A queue of segment
// words (directed corner cases, then random well-formed paths mixed with
// stray segments) feeds a clocked driver with random idle bursts; a clocked
// monitor with random back-pressure compares each box word against an
// exact integer model of the curve extrema search.
// ----------------------------------------------------------------------------
module tb_bezier_path_bounding_box_top;
	import bpbb_pkg::*;

	typedef struct {
		seg_kind_t       cmd;
		logic [IN_W-1:0] data;
		bit              last;
		bit              drain;
	} seg_word_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic [1:0]       s_tuser;
	logic             s_tlast;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	seg_word_t        seg_q[$];
	logic [OUT_W-1:0] box_q[$];
	bit               in_acc;
	bit               calm;
	bit               failed;
	int               gap_cnt;
	int               stall_cnt;
	int               n_items;
	longint           rmin_x, rmin_y, rmax_x, rmax_y;
	bit               seeded;

	bezier_path_bounding_box_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint lerp(longint p, longint q, longint t);
		longint d;
		d = q - p;
		return p + (d >>> FB) * t + (((d & ((longint'(1) << FB) - 1)) * t) >>> FB);
	endfunction

	function automatic longint quad_at(longint a, longint b, longint c, longint t);
		return lerp(lerp(a, b, t), lerp(b, c, t), t);
	endfunction

	function automatic longint cubic_at(longint a, longint b, longint c, longint d,
			longint t);
		return lerp(quad_at(a, b, c, t), quad_at(b, c, d, t), t);
	endfunction

	function automatic bit param_of(longint num, longint den, output longint t);
		longint r;
		longint q;
		t = 0;
		if (den == 0) return 0;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		if (num < 0 || num > den) return 0;
		if (num == den) begin
			t = 64'd1 << FB;
			return 1;
		end
		r = num;
		q = 0;
		for (int i = 0; i < FB; i++) begin
			r = r <<< 1;
			q = q <<< 1;
			if (r >= den) begin
				r = r - den;
				q = q | 1;
			end
		end
		t = q;
		return 1;
	endfunction

	function automatic longint isqrt(logic [127:0] d);
		logic [127:0] res;
		logic [127:0] c;
		res = 0;
		for (int b = 63; b >= 0; b--) begin
			c = res | (128'd1 << b);
			if (c * c <= d) res = c;
		end
		return longint'(res);
	endfunction

	function automatic int extrema(longint pa, longint pb, longint pc, longint pd,
			output longint t0, output longint t1);
		longint a, h, c, s, tt;
		logic signed [127:0] aw, hw, cw, disc;
		int n;
		a = -pa + 3 * pb - 3 * pc + pd;
		h = pa - 2 * pb + pc;
		c = pb - pa;
		t0 = 0;
		t1 = 0;
		n = 0;
		if (a == 0) return param_of(-c, 2 * h, t0) ? 1 : 0;
		aw = a;
		hw = h;
		cw = c;
		disc = hw * hw - aw * cw;
		if (disc < 0) return 0;
		s = isqrt(disc);
		if (param_of(-h + s, a, tt)) begin
			t0 = tt;
			n++;
		end
		if (param_of(-h - s, a, tt)) begin
			if (n == 0) t0 = tt;
			else t1 = tt;
			n++;
		end
		return n;
	endfunction

	task automatic grow(longint x, longint y);
		if (x < rmin_x) rmin_x = x;
		if (x > rmax_x) rmax_x = x;
		if (y < rmin_y) rmin_y = y;
		if (y > rmax_y) rmax_y = y;
	endtask

	task automatic track_box(logic [1:0] cmd, logic [IN_W-1:0] data, logic last);
		longint px[4], py[4], ts[4], ta, tb;
		int n, k;
		for (int i = 0; i < 4; i++) begin
			px[i] = longint'($signed(data[64*i +: 32]));
			py[i] = longint'($signed(data[64*i+32 +: 32]));
		end
		n = 0;
		if (cmd == CMD_SEED) begin
			rmin_x = px[0];
			rmax_x = px[0];
			rmin_y = py[0];
			rmax_y = py[0];
			seeded = 1;
		end else if (seeded) begin
			if (cmd == CMD_LINE) begin
				grow(px[0], py[0]);
				grow(px[1], py[1]);
			end else if (cmd == CMD_QUAD) begin
				grow(px[0], py[0]);
				grow(px[2], py[2]);
				if (param_of(px[0] - px[1], px[0] - 2 * px[1] + px[2], ta)) begin
					ts[n] = ta;
					n++;
				end
				if (param_of(py[0] - py[1], py[0] - 2 * py[1] + py[2], ta)) begin
					ts[n] = ta;
					n++;
				end
				for (int i = 0; i < n; i++)
					grow(quad_at(px[0], px[1], px[2], ts[i]),
						quad_at(py[0], py[1], py[2], ts[i]));
			end else begin
				grow(px[0], py[0]);
				grow(px[3], py[3]);
				k = extrema(px[0], px[1], px[2], px[3], ta, tb);
				if (k > 0) begin
					ts[n] = ta;
					n++;
				end
				if (k > 1) begin
					ts[n] = tb;
					n++;
				end
				k = extrema(py[0], py[1], py[2], py[3], ta, tb);
				if (k > 0) begin
					ts[n] = ta;
					n++;
				end
				if (k > 1) begin
					ts[n] = tb;
					n++;
				end
				for (int i = 0; i < n; i++)
					grow(cubic_at(px[0], px[1], px[2], px[3], ts[i]),
						cubic_at(py[0], py[1], py[2], py[3], ts[i]));
			end
		end
		if (last) begin
			if (seeded)
				box_q.push_back({rmax_y[31:0], rmax_x[31:0], rmin_y[31:0], rmin_x[31:0]});
			else
				box_q.push_back('0);
			rmin_x = 0;
			rmin_y = 0;
			rmax_x = 0;
			rmax_y = 0;
			seeded = 0;
		end
	endtask

	function automatic logic [31:0] rand_coord(int mode, logic [31:0] base);
		case (mode)
			0: return $urandom;
			1: return base + $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
			2: return base + $urandom_range(0, 32'h7FF_FFFF) - 32'h400_0000;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
		endcase
	endfunction

	task automatic add_seg(seg_kind_t cmd, logic [IN_W-1:0] data, bit last, bit drain);
		seg_word_t w;
		w.cmd = cmd;
		w.data = data;
		w.last = last;
		w.drain = drain;
		seg_q.push_back(w);
		n_items++;
	endtask

	task automatic add_rand(seg_kind_t cmd, bit last);
		logic [IN_W-1:0] d;
		logic [31:0] bx, by;
		int mode;
		mode = $urandom_range(0, 9);
		mode = (mode < 2) ? 0 : (mode < 7) ? 1 : (mode < 9) ? 2 : 3;
		bx = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
		by = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
		for (int i = 0; i < 4; i++) begin
			d[64*i +: 32] = rand_coord(mode, bx);
			d[64*i+32 +: 32] = rand_coord(mode, by);
		end
		add_seg(cmd, d, last, 0);
	endtask

	function automatic logic [IN_W-1:0] pts(int x0, int y0, int x1, int y1,
			int x2, int y2, int x3, int y3);
		return {y3, x3, y2, x2, y1, x1, y0, x0};
	endfunction

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (box_q.size() == 0) begin
				$display("%0t: unexpected box word %h", $time, m_tdata);
				failed = 1;
			end else begin
				for (int f = 0; f < 4; f++)
					if (m_tdata[32*f +: 32] !== box_q[0][32*f +: 32]) begin
						$display("%0t: box field %0d expected %h actual %h", $time, f,
							box_q[0][32*f +: 32], m_tdata[32*f +: 32]);
						failed = 1;
					end
				void'(box_q.pop_front());
			end
		end
		if (s_tvalid && s_tready)
			track_box(s_tuser, s_tdata, s_tlast);
		in_acc <= s_tvalid && s_tready;
	end

	always @(negedge clk) begin
		seg_word_t w;
		bit v;
		v = s_tvalid;
		if (arst_n && (!s_tvalid || in_acc)) begin
			v = 0;
			if (gap_cnt > 0) begin
				gap_cnt--;
			end else if (seg_q.size() > 0 && !(seg_q[0].drain && box_q.size() > 0)) begin
				if (!calm && $urandom_range(0, 5) == 0) begin
					gap_cnt = $urandom_range(1, 16) - 1;
				end else begin
					w = seg_q.pop_front();
					s_tdata <= w.data;
					s_tuser <= w.cmd;
					s_tlast <= w.last;
					v = 1;
				end
			end
			calm = seg_q.size() < 100;
		end
		s_tvalid <= v;
		if (stall_cnt > 0) begin
			stall_cnt--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_cnt = $urandom_range(1, 16) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin
		int n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_SEED;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		in_acc = 0;
		calm = 0;
		failed = 0;
		gap_cnt = 0;
		stall_cnt = 0;
		n_items = 0;
		seeded = 0;
		rmin_x = 0;
		rmin_y = 0;
		rmax_x = 0;
		rmax_y = 0;

		add_seg(CMD_LINE, pts(5, 5, 9, 9, 0, 0, 0, 0), 0, 0);
		add_seg(CMD_QUAD, pts(1, 2, 3, 4, 5, 6, 0, 0), 1, 0);
		add_seg(CMD_SEED, pts(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0), 1, 0);
		add_seg(CMD_SEED, pts(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0), 0, 0);
		add_seg(CMD_LINE, pts(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 0, 0, 0, 0), 1, 0);
		add_seg(CMD_SEED, pts(0, 0, 0, 0, 0, 0, 0, 0), 0, 1);
		add_seg(CMD_QUAD, pts(0, 0, 32'h10000, 32'h20000, 32'h20000, 0, 0, 0), 0, 0);
		add_seg(CMD_QUAD, pts(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 0, 0), 0, 0);
		add_seg(CMD_QUAD, pts(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0), 1, 0);
		add_seg(CMD_SEED, pts(100, 100, 0, 0, 0, 0, 0, 0), 0, 0);
		add_seg(CMD_CUBIC, pts(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000,
			0, 0), 0, 0);
		add_seg(CMD_CUBIC, pts(0, 0, 32'h30000, 32'h40000, 32'hFFFD_0000,
			32'h40000, 32'h10000, 0), 0, 0);
		add_seg(CMD_CUBIC, pts(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000,
			32'h30000, 32'h30000), 0, 0);
		add_seg(CMD_CUBIC, pts(0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 0, 0), 0, 0);
		add_seg(CMD_CUBIC, pts(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF), 1, 0);
		add_seg(CMD_SEED, pts(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0), 0, 0);
		add_seg(CMD_CUBIC, pts(0, 0, 32'h20000, 32'h10000, 32'h10000, 32'h20000,
			32'h30000, 0), 1, 0);
		add_seg(CMD_CUBIC, pts(1, 1, 2, 2, 3, 3, 4, 4), 1, 0);

		while (n_items < 750) begin
			if ($urandom_range(0, 99) < 85) begin
				add_rand(CMD_SEED, 0);
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					add_rand(seg_kind_t'($urandom_range(1, 3)), i == n - 1);
			end else begin
				add_rand(seg_kind_t'($urandom_range(0, 3)), $urandom_range(0, 1));
			end
			if (n_items > 400 && n_items < 410) begin
				add_seg(CMD_SEED, pts(7, 7, 0, 0, 0, 0, 0, 0), 1, 1);
			end
		end
		add_rand(CMD_SEED, 1);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (seg_q.size() == 0 && !s_tvalid && box_q.size() == 0);
		repeat (600) @(posedge clk);
		if (!failed && box_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#50000000;
		$display("FAIL");
		$finish;
	end

endmodule
